FILE: hw/rtl/glb_container_chunk_parser_unit_macros.svh
// assertion macros for the container chunk parser
// no dependencies; included by the top level only
`ifndef GLB_CONTAINER_CHUNK_PARSER_UNIT_MACROS_SVH
`define GLB_CONTAINER_CHUNK_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset only
`define GCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// checked on every edge, reset included
`define GCP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define GCP_ASSERT(lbl, prop, msg)
`define GCP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/gcp_pkg.sv
// shared types, codes and constants of the container chunk parser
// no dependencies
package gcp_pkg;

    // offset arithmetic width of binary chunk reports
    localparam int OFFSET_BITS = 32;
    localparam int OFF_W       = OFFSET_BITS + 1;
    localparam logic [32:0] OFF_MASK =
        (OFF_W >= 33) ? {33{1'b1}} : 33'((34'd1 << OFF_W) - 34'd1);

    // container words, little-endian as they build up in the shift register
    localparam logic [31:0] MAGIC_WORD = 32'h4654_6C67;
    localparam logic [31:0] JSON_WORD  = 32'h4E4F_534A;
    localparam logic [31:0] BIN_WORD   = 32'h004E_4942;
    localparam logic [31:0] VERSION_2  = 32'd2;

    localparam logic [31:0] FILE_HDR_BYTES  = 32'd12;
    localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;
    // smallest blob that still has room for a chunk header after the file header
    localparam logic [31:0] MIN_CHUNK_BLOB  = FILE_HDR_BYTES + CHUNK_HDR_BYTES;

    // event codes
    localparam logic [2:0] EV_NOT_CONTAINER = 3'd0;
    localparam logic [2:0] EV_TOO_SHORT     = 3'd1;
    localparam logic [2:0] EV_TOO_LARGE     = 3'd2;
    localparam logic [2:0] EV_BIN_CHUNK     = 3'd3;
    localparam logic [2:0] EV_OVERRUN       = 3'd4;
    localparam logic [2:0] EV_FINISHED      = 3'd5;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BLOB_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       blob_start;
    } gcp_in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [32:0] chunk_offset;
        logic [31:0] payload_len;
        logic        success;
    } gcp_out_t;

    // one result handed from the parser to the result queue
    typedef struct packed {
        logic     valid;
        gcp_out_t data;
    } gcp_push_t;

endpackage

FILE: hw/rtl/gcp_parser_core.sv
// byte-serial parse state and per-byte decision logic
// depends on gcp_pkg
module gcp_parser_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  gcp_pkg::gcp_in_t   in_beat,
    input  logic [31:0]        blob_length,
    input  logic [31:0]        base_offset,
    output gcp_pkg::gcp_push_t push
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CHUNK   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [2:0] IDX_LEN_DONE = 3'd3;
    localparam logic [2:0] IDX_END_CALC = 3'd4;
    localparam logic [2:0] IDX_LIM_CALC = 3'd5;
    localparam logic [2:0] IDX_TYPE     = 3'd7;

    logic [31:0] pos_reg, pos_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] word_reg, word_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [32:0] pend_reg, pend_next;
    logic [33:0] pend8_reg, pend8_next;
    logic [31:0] json_off_reg, json_off_next;
    logic [31:0] json_len_reg, json_len_next;
    logic        magic_ok_reg, magic_ok_next;
    logic        version_ok_reg, version_ok_next;

    // effective state after an optional restart
    logic        clr;
    logic [31:0] pos_e;
    logic [1:0]  phase_e;
    logic [2:0]  hdr_e;
    logic [31:0] word_new;
    logic [32:0] data_off;
    logic [32:0] abs_off;
    logic        is_bin;

    assign clr      = in_beat.blob_start;
    assign pos_e    = clr ? 32'd0 : pos_reg;
    assign phase_e  = clr ? PH_HEADER : phase_reg;
    assign hdr_e    = clr ? 3'd0 : hdr_cnt_reg;
    assign word_new = {in_beat.data_byte, word_reg[31:8]};
    assign data_off = {1'b0, pos_e} + 33'd1;
    assign abs_off  = ({1'b0, base_offset} + data_off) & gcp_pkg::OFF_MASK;
    assign is_bin   = (word_new == gcp_pkg::BIN_WORD);

    // per-byte step
    always_comb begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        word_next       = word_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        chunk_len_next  = chunk_len_reg;
        pend_next       = pend_reg;
        pend8_next      = pend8_reg;
        json_off_next   = json_off_reg;
        json_len_next   = json_len_reg;
        magic_ok_next   = magic_ok_reg;
        version_ok_next = version_ok_reg;
        push            = '0;

        if (fire) begin
            pos_next     = pos_e;
            phase_next   = phase_e;
            hdr_cnt_next = hdr_e;
            if (clr) begin
                json_off_next   = '0;
                json_len_next   = '0;
                magic_ok_next   = 1'b0;
                version_ok_next = 1'b0;
            end

            if (phase_e == PH_DONE) begin
                // blob closed, byte ignored
            end else if (phase_e == PH_HEADER && pos_e == 32'd0 &&
                         blob_length < gcp_pkg::FILE_HDR_BYTES) begin
                phase_next             = PH_DONE;
                push.valid             = 1'b1;
                push.data.event_kind   = gcp_pkg::EV_TOO_SHORT;
            end else if (pos_e < blob_length) begin
                word_next = word_new;
                pos_next  = pos_e + 32'd1;
                case (phase_e)
                    PH_HEADER: begin
                        if (pos_e == 32'd3) begin
                            magic_ok_next = (word_new == gcp_pkg::MAGIC_WORD);
                        end else if (pos_e == 32'd7) begin
                            version_ok_next = (word_new == gcp_pkg::VERSION_2);
                        end else if (pos_e == 32'd11) begin
                            phase_next = PH_DONE;
                            push.valid = 1'b1;
                            if (!(magic_ok_next && version_ok_next)) begin
                                push.data.event_kind = gcp_pkg::EV_NOT_CONTAINER;
                            end else if (word_new > blob_length) begin
                                push.data.event_kind = gcp_pkg::EV_TOO_LARGE;
                            end else if (blob_length < gcp_pkg::MIN_CHUNK_BLOB) begin
                                push.data.event_kind   = gcp_pkg::EV_FINISHED;
                                push.data.chunk_offset = {1'b0, json_off_next};
                                push.data.payload_len  = json_len_next;
                                push.data.success      = (json_len_next != 32'd0);
                            end else begin
                                push.valid   = 1'b0;
                                phase_next   = PH_CHUNK;
                                hdr_cnt_next = 3'd0;
                            end
                        end
                    end
                    PH_CHUNK: begin
                        hdr_cnt_next = hdr_e + 3'd1;
                        if (hdr_e == IDX_LEN_DONE) begin
                            chunk_len_next = word_new;
                        end else if (hdr_e == IDX_END_CALC) begin
                            // payload end: type word ends three bytes later
                            pend_next = {1'b0, pos_e} + 33'd4 + {1'b0, chunk_len_reg};
                        end else if (hdr_e == IDX_LIM_CALC) begin
                            pend8_next = {1'b0, pend_reg} + {2'b0, gcp_pkg::CHUNK_HDR_BYTES};
                        end else if (hdr_e == IDX_TYPE) begin
                            if (pend_reg > {1'b0, blob_length}) begin
                                phase_next             = PH_DONE;
                                push.valid             = 1'b1;
                                push.data.event_kind   = gcp_pkg::EV_OVERRUN;
                                push.data.chunk_offset = data_off;
                                push.data.payload_len  = chunk_len_reg;
                            end else begin
                                if (word_new == gcp_pkg::JSON_WORD) begin
                                    json_off_next = data_off[31:0];
                                    json_len_next = chunk_len_reg;
                                end
                                if (chunk_len_reg != 32'd0) begin
                                    phase_next = PH_PAYLOAD;
                                end else begin
                                    phase_next = PH_CHUNK;
                                end
                                if (chunk_len_reg == 32'd0 &&
                                    pend8_reg > {2'b0, blob_length}) begin
                                    // empty last chunk closes the walk
                                    phase_next             = PH_DONE;
                                    push.valid             = 1'b1;
                                    push.data.event_kind   = gcp_pkg::EV_FINISHED;
                                    push.data.chunk_offset = {1'b0, json_off_next};
                                    push.data.payload_len  = json_len_next;
                                    push.data.success      = (json_len_next != 32'd0);
                                end else if (is_bin) begin
                                    push.valid             = 1'b1;
                                    push.data.event_kind   = gcp_pkg::EV_BIN_CHUNK;
                                    push.data.chunk_offset = abs_off;
                                    push.data.payload_len  = chunk_len_reg;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        if (data_off == pend_reg) begin
                            hdr_cnt_next = 3'd0;
                            if (pend8_reg > {2'b0, blob_length}) begin
                                phase_next             = PH_DONE;
                                push.valid             = 1'b1;
                                push.data.event_kind   = gcp_pkg::EV_FINISHED;
                                push.data.chunk_offset = {1'b0, json_off_reg};
                                push.data.payload_len  = json_len_reg;
                                push.data.success      = (json_len_reg != 32'd0);
                            end else begin
                                phase_next = PH_CHUNK;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            phase_reg      <= PH_HEADER;
            hdr_cnt_reg    <= '0;
            json_off_reg   <= '0;
            json_len_reg   <= '0;
            magic_ok_reg   <= 1'b0;
            version_ok_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            json_off_reg   <= json_off_next;
            json_len_reg   <= json_len_next;
            magic_ok_reg   <= magic_ok_next;
            version_ok_reg <= version_ok_next;
        end
    end

    // datapath state, always written before it is read within a blob
    always_ff @(posedge aclk) begin
        word_reg      <= word_next;
        chunk_len_reg <= chunk_len_next;
        pend_reg      <= pend_next;
        pend8_reg     <= pend8_next;
    end

endmodule

FILE: hw/rtl/gcp_result_q.sv
// two-entry result queue between the parser and the result channel
// depends on gcp_pkg
module gcp_result_q (
    input  logic               aclk,
    input  logic               aresetn,
    input  gcp_pkg::gcp_push_t push,
    output logic               space,
    output logic               m_valid,
    input  logic               m_ready,
    output gcp_pkg::gcp_out_t  m_data
);

    logic [1:0]        cnt_reg, cnt_next;
    gcp_pkg::gcp_out_t head_reg, head_next;
    gcp_pkg::gcp_out_t tail_reg, tail_next;
    logic              pop;

    assign space   = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = head_reg;
    assign pop     = m_valid && m_ready;

    // occupancy and entry moves
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        case (cnt_reg)
            2'd0: begin
                if (push.valid) begin
                    head_next = push.data;
                    cnt_next  = 2'd1;
                end
            end
            2'd1: begin
                if (push.valid && pop) begin
                    head_next = push.data;
                end else if (push.valid) begin
                    tail_next = push.data;
                    cnt_next  = 2'd2;
                end else if (pop) begin
                    cnt_next = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    head_next = tail_reg;
                    cnt_next  = 2'd1;
                end
            end
            default: begin
                cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: hw/rtl/glb_container_chunk_parser_unit.sv
// top level of the binary scene container chunk parser
// depends on gcp_pkg, gcp_parser_core, gcp_result_q and the macros header
//
// Usage:
//   s_valid/s_ready/s_data carry one blob byte per beat, from offset zero;
//   blob_start on the first byte restarts the parse. m_valid/m_ready/m_data
//   carry result beats: header errors, one beat per binary chunk, a chunk
//   overrun, or the closing beat with the JSON chunk position and success.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write blob_length (index 0) and
//   base_offset (index 1); cfg_ready is always high and other indexes are
//   dropped. Write them between blobs.
//   Results are registered in the queue; m_data shows its head. Throughput:
//   one byte per cycle while s_ready is high; the per-byte step is a single
//   register update, and chunk end positions are summed in the header bytes.
//   Stalls: results go through a two-entry queue, so bytes keep flowing
//   while one result waits; s_ready drops only while both entries are full.
//   Reset: parser back to the file header at offset zero, both registers
//   zero, the queue empty.
module glb_container_chunk_parser_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  gcp_pkg::gcp_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output gcp_pkg::gcp_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);

    `include "glb_container_chunk_parser_unit_macros.svh"

    logic [31:0]        blob_length_reg;
    logic [31:0]        base_offset_reg;
    logic               fire;
    logic               space;
    gcp_pkg::gcp_push_t push;

    assign cfg_ready = 1'b1;
    assign s_ready   = space;
    assign fire      = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blob_length_reg <= '0;
            base_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gcp_pkg::REG_BLOB_LENGTH: blob_length_reg <= cfg_data;
                gcp_pkg::REG_BASE_OFFSET: base_offset_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    gcp_parser_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .in_beat     (s_data),
        .blob_length (blob_length_reg),
        .base_offset (base_offset_reg),
        .push        (push)
    );

    gcp_result_q u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .space   (space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // checks
    `GCP_ASSERT(a_push_only_on_beat, push.valid |-> fire, "result without an input beat")
    `GCP_ASSERT(a_full_keeps_output, !s_ready |-> m_valid, "queue full but output idle")
    `GCP_ASSERT(a_success_finished, (m_valid && m_data.success) |-> (m_data.event_kind == gcp_pkg::EV_FINISHED), "success on a non-final result")
    `GCP_ASSERT_RST(a_reset_empties, !aresetn |=> (!m_valid && s_ready), "queue not empty after reset")

endmodule
